/* hdl/voxel_segment_length_density_core_defines.svh */
// assertion macros shared by the voxel segment length density block
`ifndef VOXEL_SEGMENT_LENGTH_DENSITY_CORE_DEFINES_SVH
`define VOXEL_SEGMENT_LENGTH_DENSITY_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VSLD_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define VSLD_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define VSLD_ASSERT_IMP(lbl, clk, rst, a, c)
`define VSLD_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

/* hdl/vsld_pkg.sv */
// shared types and constants of the voxel segment length density block
`default_nettype none
package vsld_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int SIZE_W = 31;
  localparam int SUM_W = 47;
  localparam int DENS_W = 32;
  localparam int T_BITS = 30;
  localparam logic [SIZE_W-1:0] VOXEL_SIZE_RESET = SIZE_W'(65536);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_AXIS, S_DIVE, S_DIVX, S_CHECK,
    S_SQRT, S_ACC, S_DENS, S_DRUN, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_ENTRY, DIV_EXIT, DIV_DENS_FIRST, DIV_DENS_NEXT
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     axis;
    logic     axis_inc;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_entry;
    logic     take_exit;
    logic     sq_add;
    logic     sqrt_start;
    logic     lmul;
    logic     acc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic seg_valid;
    logic last;
    logic ax_last;
    logic div_busy;
    logic sqrt_busy;
    logic empty;
    logic pass_last;
    logic out_full;
  } status_t;
endpackage
`default_nettype wire

/* hdl/vsld_if.sv */
// request and result channel interfaces
`default_nettype none
interface vsld_seg_if;
  logic valid;
  logic ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic segment_valid;
  logic last_segment;
  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 center_x, center_y, center_z, segment_valid, last_segment,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               center_x, center_y, center_z, segment_valid, last_segment,
               output ready);
endinterface

interface vsld_res_if;
  logic valid;
  logic ready;
  logic [46:0] total_length;
  logic [31:0] density;
  modport source(output valid, total_length, density, input ready);
  modport sink(input valid, total_length, density, output ready);
endinterface
`default_nettype wire

/* hdl/vsld_ctrl.sv */
// sequencer for clipping, length and density steps
`default_nettype none
module vsld_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire vsld_pkg::status_t status,
  output vsld_pkg::cmd_t         cmd
);
  import vsld_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (status.seg_valid) state_next = S_AXIS;
        else if (status.last) state_next = S_DENS;
        else state_next = S_IDLE;
      end
      S_AXIS:     state_next = S_DIVE;
      S_DIVE:     if (!status.div_busy) state_next = S_DIVX;
      S_DIVX: begin
        if (!status.div_busy) state_next = status.ax_last ? S_CHECK : S_AXIS;
      end
      S_CHECK: begin
        if (!status.empty) state_next = S_SQRT;
        else if (status.last) state_next = S_DENS;
        else state_next = S_IDLE;
      end
      S_SQRT:     if (!status.sqrt_busy) state_next = S_ACC;
      S_ACC:      state_next = status.last ? S_DENS : S_IDLE;
      S_DENS:     state_next = S_DRUN;
      S_DRUN:     if (!status.div_busy && status.pass_last) state_next = S_OUT;
      S_OUT:      if (!status.out_full) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: ;
      S_AXIS: begin
        cmd.axis = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_ENTRY;
      end
      S_DIVE: begin
        if (!status.div_busy) begin
          cmd.take_entry = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_EXIT;
        end
      end
      S_DIVX: begin
        if (!status.div_busy) begin
          cmd.take_exit = 1'b1;
          cmd.sq_add = 1'b1;
          cmd.axis_inc = !status.ax_last;
        end
      end
      S_CHECK:  cmd.sqrt_start = !status.empty;
      S_SQRT:   cmd.lmul = !status.sqrt_busy;
      S_ACC:    cmd.acc = 1'b1;
      S_DENS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_DENS_FIRST;
      end
      S_DRUN: begin
        if (!status.div_busy && !status.pass_last) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_DENS_NEXT;
        end
      end
      S_OUT:    cmd.out_load = !status.out_full;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/vsld_dp.sv */
// datapath: slab bounds, shared divider, square root, length sum and density
`default_nettype none
`include "voxel_segment_length_density_core_defines.svh"
module vsld_dp #(
  parameter int FRAC_BITS = vsld_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [vsld_pkg::SIZE_W-1:0]         cfg_data,
  input  wire logic signed [vsld_pkg::COORD_W-1:0] in_start [3],
  input  wire logic signed [vsld_pkg::COORD_W-1:0] in_end [3],
  input  wire logic signed [vsld_pkg::COORD_W-1:0] in_center [3],
  input  wire logic                                in_seg_valid,
  input  wire logic                                in_last,
  input  wire vsld_pkg::cmd_t                      cmd,
  output vsld_pkg::status_t                        status,
  input  wire logic                                out_take,
  output logic                                     out_valid,
  output logic [vsld_pkg::SUM_W-1:0]               out_total,
  output logic [vsld_pkg::DENS_W-1:0]              out_density
);
  import vsld_pkg::*;

  localparam int QW = SUM_W + 3 * FRAC_BITS;
  localparam int CNTW = $clog2(QW + 1);
  localparam int BW = COORD_W + 3;
  localparam int DVW = COORD_W + 2;
  localparam int SQW = COORD_W + 1;
  localparam int SSW = 2 * SQW;
  localparam int SCW = $clog2(SQW + 1);
  localparam int TW = T_BITS + 1;
  localparam int PW = SQW + TW;
  localparam int CLW = PW - T_BITS;

  logic [SIZE_W-1:0] voxel_size;
  logic signed [COORD_W-1:0] st [3];
  logic signed [COORD_W-1:0] en [3];
  logic signed [COORD_W-1:0] ce [3];
  logic seg_valid, last;
  logic [1:0] ax;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) voxel_size <= VOXEL_SIZE_RESET;
    else if (cfg_we) voxel_size <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st <= in_start;
      en <= in_end;
      ce <= in_center;
      seg_valid <= in_seg_valid;
      last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) ax <= '0;
    else if (cmd.axis_inc) ax <= ax + 2'd1;
  end

  // slab bounds at doubled scale for the current axis
  logic signed [COORD_W-1:0] p0, p1, c;
  logic signed [BW-1:0] c2, p2, s_ext, lo, hi, d, m_full, n_e, n_x, n_sel;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0] adiff;
  logic [DVW-1:0] m;
  logic d_zero, d_pos, reject_ax;

  always_comb begin
    p0 = st[ax];
    p1 = en[ax];
    c = ce[ax];
    c2 = {{2{c[COORD_W-1]}}, c, 1'b0};
    p2 = {{2{p0[COORD_W-1]}}, p0, 1'b0};
    s_ext = {4'b0, voxel_size};
    lo = c2 - s_ext;
    hi = c2 + s_ext;
    diff = {p1[COORD_W-1], p1} - {p0[COORD_W-1], p0};
    d = {diff[COORD_W], diff, 1'b0};
    d_zero = (d == '0);
    d_pos = !d[BW-1] && !d_zero;
    m_full = d[BW-1] ? -d : d;
    m = m_full[DVW-1:0];
    n_e = d_pos ? (lo - p2) : (p2 - hi);
    n_x = d_pos ? (hi - p2) : (p2 - lo);
    n_sel = (cmd.div_sel == DIV_ENTRY) ? n_e : n_x;
    reject_ax = d_zero && ((p2 < lo) || (p2 > hi));
    adiff = diff[COORD_W] ? -diff : diff;
  end

  // restoring divider, one quotient bit a cycle
  logic [DVW-1:0] rem, divisor;
  logic [QW-1:0] dvd, quo;
  logic [CNTW-1:0] cnt;
  logic [1:0] pass;
  logic [DVW:0] r2, r2_sub;
  logic div_busy, ge;

  assign div_busy = (cnt != '0);
  assign r2 = {rem, dvd[QW-1]};
  assign r2_sub = r2 - {1'b0, divisor};
  assign ge = (r2 >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      case (cmd.div_sel)
        DIV_ENTRY, DIV_EXIT: begin
          rem <= n_sel[DVW-1:0];
          dvd <= '0;
          divisor <= m;
          if (d_zero) begin
            quo <= (cmd.div_sel == DIV_ENTRY) ? '0 : (QW'(1) << T_BITS);
            cnt <= '0;
          end else if (n_sel[BW-1] || n_sel == '0) begin
            quo <= '0;
            cnt <= '0;
          end else if (n_sel >= $signed({1'b0, m})) begin
            quo <= QW'(1) << T_BITS;
            cnt <= '0;
          end else begin
            quo <= '0;
            cnt <= CNTW'(T_BITS);
          end
        end
        default: begin
          rem <= '0;
          divisor <= DVW'(voxel_size);
          dvd <= (cmd.div_sel == DIV_DENS_FIRST) ?
                 {sum, {(3 * FRAC_BITS){1'b0}}} : quo;
          quo <= '0;
          cnt <= CNTW'(QW);
        end
      endcase
    end else if (div_busy) begin
      rem <= ge ? r2_sub[DVW-1:0] : r2[DVW-1:0];
      quo <= {quo[QW-2:0], ge};
      dvd <= {dvd[QW-2:0], 1'b0};
      cnt <= cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DIV_DENS_FIRST) pass <= '0;
    else if (cmd.div_start && cmd.div_sel == DIV_DENS_NEXT) pass <= pass + 2'd1;
  end

  // clip window and sum of squares
  logic [TW-1:0] tmin, tmax;
  logic [2*COORD_W-1:0] sq;
  logic [SSW-1:0] ss;
  logic reject;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tmin <= '0;
      tmax <= TW'(1) << T_BITS;
      ss <= '0;
      reject <= 1'b0;
    end else begin
      if (cmd.axis) begin
        sq <= adiff[COORD_W-1:0] * adiff[COORD_W-1:0];
        if (reject_ax) reject <= 1'b1;
      end
      if (cmd.take_entry && quo[TW-1:0] > tmin) tmin <= quo[TW-1:0];
      if (cmd.take_exit && quo[TW-1:0] < tmax) tmax <= quo[TW-1:0];
      if (cmd.sq_add) ss <= ss + SSW'(sq);
    end
  end

  // digit-by-digit square root, one root bit a cycle
  logic [SSW-1:0] rad;
  logic [SQW:0] sq_rem;
  logic [SQW-1:0] root;
  logic [SCW-1:0] scnt;
  logic [SQW+2:0] sr, trial, sr_sub;
  logic sqrt_busy, sge;

  assign sqrt_busy = (scnt != '0);
  assign sr = {sq_rem, rad[SSW-1:SSW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign sge = (sr >= trial);
  assign sr_sub = sr - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
    end else if (cmd.sqrt_start) begin
      rad <= ss;
      sq_rem <= '0;
      root <= '0;
      scnt <= SCW'(SQW);
    end else if (sqrt_busy) begin
      sq_rem <= sge ? sr_sub[SQW:0] : sr[SQW:0];
      root <= {root[SQW-2:0], sge};
      rad <= {rad[SSW-3:0], 2'b00};
      scnt <= scnt - SCW'(1);
    end
  end

  // clipped length and saturating sum
  logic [PW-1:0] prod;
  logic [CLW-1:0] clip;
  logic [SUM_W:0] tot;

  assign prod = PW'(root) * PW'(tmax - tmin);
  assign tot = {1'b0, sum} + (SUM_W + 1)'(clip);

  always_ff @(posedge clk) begin
    if (cmd.lmul) clip <= prod[PW-1:T_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) sum <= '0;
    else if (cmd.acc) sum <= tot[SUM_W] ? {SUM_W{1'b1}} : tot[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total <= sum;
      out_density <= (voxel_size == '0 || quo[QW-1:DENS_W] != '0) ?
                     {DENS_W{1'b1}} : quo[DENS_W-1:0];
    end
  end

  always_comb begin
    status.seg_valid = seg_valid;
    status.last = last;
    status.ax_last = (ax == 2'd2);
    status.div_busy = div_busy;
    status.sqrt_busy = sqrt_busy;
    status.empty = reject || (tmin >= tmax);
    status.pass_last = (pass == 2'd2);
    status.out_full = out_valid;
  end

  `VSLD_ASSERT_IMP(a_div_start_idle, clk, rst, cmd.div_start, !div_busy)
  `VSLD_ASSERT_IMP(a_out_load_free, clk, rst, cmd.out_load, !out_valid)
  `VSLD_ASSERT_NXT(a_sqrt_runs, clk, rst, cmd.sqrt_start, sqrt_busy)
endmodule
`default_nettype wire

/* hdl/voxel_segment_length_density_core.sv */
// top level: clipped segment length sum and density for one cubic voxel
//
//  channel  dir  handshake        content
//  seg      in   valid/ready      segment endpoints, voxel centre, valid, last flags
//  res      out  valid/ready      total_length, density
//  cfg      in   voxel_size_we    voxel_size write, no read-back
//
// a segment's processing is paced by the shared one-bit-a-cycle divider (six clamped
// quotients) and the 33-step square root
// a last item adds three density passes through the divider
// one item in flight; seg.ready is high only while the sequencer is idle
// the result register holds one result; a stalled result stalls the next last item
// synchronous reset clears the sequencer, sum and result valid, and sets size to 1.0
`default_nettype none
module voxel_segment_length_density_core #(
  parameter int FRAC_BITS = vsld_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  vsld_seg_if.sink                         seg,
  vsld_res_if.source                       res,
  input  wire logic                        voxel_size_we,
  input  wire logic [vsld_pkg::SIZE_W-1:0] voxel_size_wdata
);
  import vsld_pkg::*;

  cmd_t cmd;
  status_t status;
  logic signed [COORD_W-1:0] in_start [3];
  logic signed [COORD_W-1:0] in_end [3];
  logic signed [COORD_W-1:0] in_center [3];

  assign in_start[0] = seg.start_x;
  assign in_start[1] = seg.start_y;
  assign in_start[2] = seg.start_z;
  assign in_end[0] = seg.end_x;
  assign in_end[1] = seg.end_y;
  assign in_end[2] = seg.end_z;
  assign in_center[0] = seg.center_x;
  assign in_center[1] = seg.center_y;
  assign in_center[2] = seg.center_z;

  vsld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg.valid),
    .in_ready (seg.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vsld_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (voxel_size_we),
    .cfg_data     (voxel_size_wdata),
    .in_start     (in_start),
    .in_end       (in_end),
    .in_center    (in_center),
    .in_seg_valid (seg.segment_valid),
    .in_last      (seg.last_segment),
    .cmd          (cmd),
    .status       (status),
    .out_take     (res.ready),
    .out_valid    (res.valid),
    .out_total    (res.total_length),
    .out_density  (res.density)
  );
endmodule
`default_nettype wire

/* bench/vsld_checker.sv */
// watches the segment and result channels, predicts each result and compares
`timescale 1ns / 100ps
`default_nettype none
module vsld_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  vsld_seg_if              seg,
  vsld_res_if              res,
  input  wire logic        size_we,
  input  wire logic [30:0] size_wdata,
  output int               errors,
  output int               pending,
  output int               seg_count,
  output int               res_count
);
  import vsld_pkg::*;

  localparam logic [46:0] SUM_SAT = {47{1'b1}};
  localparam logic [31:0] DENS_SAT = 32'hFFFF_FFFF;
  localparam longint unsigned T_UNIT = 64'd1 << T_BITS;

  typedef struct packed {
    logic [46:0] total_length;
    logic [31:0] density;
  } voxel_result_t;

  logic [30:0]   edge_size;
  logic [46:0]   run_length;
  voxel_result_t voxel_results[$];

  // clamped quotient n/m in q1.30, m > 0
  function automatic longint unsigned slab_t(longint n, longint m);
    longint unsigned un;
    if (n <= 0) return 0;
    if (n >= m) return T_UNIT;
    un = longint'(n);
    return (un << T_BITS) / longint'(m);
  endfunction

  function automatic logic [34:0] floor_sqrt(logic [71:0] v);
    logic [34:0] r;
    logic [34:0] cand;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = r | (35'd1 << b);
      if (72'(cand) * 72'(cand) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [46:0] clipped(logic [31:0] co[9], logic [30:0] sz);
    longint unsigned t_in, t_out, te, tx;
    longint p0, p1, c, lo, hi, p, d, ad;
    logic [71:0] sq;
    logic [71:0] prod;
    t_in = 0;
    t_out = T_UNIT;
    sq = '0;
    for (int ax = 0; ax < 3; ax++) begin
      p0 = longint'($signed(co[ax]));
      p1 = longint'($signed(co[3+ax]));
      c  = longint'($signed(co[6+ax]));
      lo = 2*c - longint'(sz);
      hi = 2*c + longint'(sz);
      p = 2*p0;
      d = 2*(p1 - p0);
      if (d == 0) begin
        if (p < lo || p > hi) return '0;
        te = 0;
        tx = T_UNIT;
      end else if (d > 0) begin
        te = slab_t(lo - p, d);
        tx = slab_t(hi - p, d);
      end else begin
        te = slab_t(p - hi, -d);
        tx = slab_t(p - lo, -d);
      end
      if (te > t_in) t_in = te;
      if (tx < t_out) t_out = tx;
      ad = (p1 >= p0) ? (p1 - p0) : (p0 - p1);
      sq = sq + 72'(ad) * 72'(ad);
    end
    if (t_in >= t_out) return '0;
    prod = 72'(floor_sqrt(sq)) * 72'(t_out - t_in);
    return 47'(prod >> T_BITS);
  endfunction

  function automatic logic [31:0] density_of(logic [46:0] total, logic [30:0] sz);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    if (sz == 0) return DENS_SAT;
    num = 128'(total) << 48;
    den = 128'(sz) * 128'(sz) * 128'(sz);
    q = num / den;
    if (q > 128'(DENS_SAT)) return DENS_SAT;
    return q[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0]   co[9];
    logic [46:0]   add;
    voxel_result_t want;
    int            bad;
    if (rst) begin
      edge_size = VOXEL_SIZE_RESET;
      run_length = '0;
      voxel_results.delete();
      errors <= 0;
      seg_count <= 0;
      res_count <= 0;
    end else begin
      bad = 0;
      if (size_we) edge_size = size_wdata;
      if (seg.valid && seg.ready) begin
        seg_count <= seg_count + 1;
        co = '{seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z,
               seg.center_x, seg.center_y, seg.center_z};
        if (seg.segment_valid) begin
          add = clipped(co, edge_size);
          run_length = (add > SUM_SAT - run_length) ? SUM_SAT : run_length + add;
        end
        if (seg.last_segment) begin
          voxel_results.push_back('{run_length, density_of(run_length, edge_size)});
          run_length = '0;
        end
      end
      if (res.valid && res.ready) begin
        res_count <= res_count + 1;
        if (voxel_results.size() == 0) begin
          $error("result with no request waiting");
          bad = bad + 1;
        end else begin
          want = voxel_results.pop_front();
          if (res.total_length !== want.total_length) begin
            $error("total_length expected %0d actual %0d", want.total_length,
                   res.total_length);
            bad = bad + 1;
          end
          if (res.density !== want.density) begin
            $error("density expected %0d actual %0d", want.density, res.density);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= voxel_results.size();
  end
endmodule
`default_nettype wire

/* bench/testbench.sv */
// stimulus and verdict for the voxel segment length density block
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import vsld_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        size_we = 1'b0;
  logic [30:0] size_wdata = '0;
  int          errors, pending, seg_count, res_count;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          sizes_used = 0;
  logic [30:0] cur_size = VOXEL_SIZE_RESET;

  vsld_seg_if seg ();
  vsld_res_if res ();

  voxel_segment_length_density_core dut (
    .clk(clk), .rst(rst), .seg(seg), .res(res),
    .voxel_size_we(size_we), .voxel_size_wdata(size_wdata)
  );

  vsld_checker chk (
    .clk(clk), .rst(rst), .seg(seg), .res(res),
    .size_we(size_we), .size_wdata(size_wdata),
    .errors(errors), .pending(pending), .seg_count(seg_count), .res_count(res_count)
  );

  always #6 clk = ~clk;

  initial begin
    seg.valid = 1'b0;
    {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z} = '0;
    {seg.center_x, seg.center_y, seg.center_z} = '0;
    seg.segment_valid = 1'b0;
    seg.last_segment = 1'b0;
    res.ready = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send(logic [31:0] co[9], bit sv, bit last, bit more);
    seg.start_x <= co[0]; seg.start_y <= co[1]; seg.start_z <= co[2];
    seg.end_x <= co[3]; seg.end_y <= co[4]; seg.end_z <= co[5];
    seg.center_x <= co[6]; seg.center_y <= co[7]; seg.center_z <= co[8];
    seg.segment_valid <= sv;
    seg.last_segment <= last;
    seg.valid <= 1'b1;
    do @(posedge clk); while (!seg.ready);
    if (!more) begin
      seg.valid <= 1'b0;
    end else if ($urandom_range(99) < tx_idle) begin
      seg.valid <= 1'b0;
      repeat ($urandom_range(1, 300)) @(posedge clk);
    end
  endtask

  task automatic write_size(logic [30:0] v);
    wait (pending == 0);
    repeat (700) @(posedge clk);
    size_we <= 1'b1;
    size_wdata <= v;
    @(posedge clk);
    size_we <= 1'b0;
    cur_size = v;
    sizes_used++;
  endtask

  function automatic logic [31:0] near(logic [31:0] c, logic [30:0] sz);
    longint span, off;
    span = (sz == 0) ? 1 : longint'(sz);
    off = longint'({$urandom, $urandom} % (64'(4*span + 1))) - 2*span;
    return 32'(longint'($signed(c)) + off);
  endfunction

  task automatic random_item(bit more);
    logic [31:0] co[9];
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) co[i] = $urandom;
    if (kind >= 15) begin
      // small centres keep most boxes in range
      for (int i = 6; i < 9; i++) if ($urandom_range(1)) co[i] = $urandom_range(0, 1 << 20);
      for (int i = 0; i < 6; i++) co[i] = near(co[6 + i % 3], cur_size);
      if (kind < 30) co[3 + $urandom_range(2)] = co[$urandom_range(2)];
      if (kind < 40) co[$urandom_range(2) + 3] = co[$urandom_range(2)];
      if (kind < 45) for (int i = 0; i < 3; i++) co[3+i] = co[i];
      if (kind >= 45 && kind < 55) begin
        for (int i = 0; i < 3; i++) co[3+i] = co[i];
        co[3 + $urandom_range(2)] = near(co[6], cur_size);
      end
    end
    send(co, $urandom_range(9) != 0, $urandom_range(5) == 0, more);
  endtask

  task automatic directed();
    logic [31:0] lo, hi, h;
    lo = 32'h8000_0000;
    hi = 32'h7FFF_FFFF;
    h = 32'h0000_8000;
    // full span through a unit box, both ways
    send('{lo, lo, lo, hi, hi, hi, 0, 0, 0}, 1, 1, 1);
    send('{hi, lo, hi, lo, hi, lo, 0, 0, 0}, 1, 1, 1);
    // inside the box
    send('{32'hFFFF_C000, 0, 0, 32'h0000_4000, 32'h0000_1000, 0, 0, 0, 0}, 1, 1, 1);
    // miss, and touching only a corner
    send('{32'h0010_0000, 0, 0, 32'h0020_0000, 32'h0001_0000, 0, 0, 0, 0}, 1, 1, 1);
    send('{h, h, h, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0}, 1, 1, 1);
    // degenerate
    send('{32'h1234, 32'h10, 0, 32'h1234, 32'h10, 0, 0, 0, 0}, 1, 1, 1);
    // axis-parallel inside and outside the slab
    send('{32'hFFF0_0000, 32'h1000, 0, 32'h0010_0000, 32'h1000, 0, 0, 0, 0}, 1, 1, 1);
    send('{32'hFFF0_0000, 32'h0009_0000, 0, 32'h0010_0000, 32'h0009_0000, 0, 0, 0, 0},
         1, 1, 1);
    // accumulate without last, then invalid segments
    send('{lo, 0, 0, hi, 0, 0, 0, 0, 0}, 1, 0, 1);
    send('{0, lo, 0, 0, hi, 0, 0, 0, 0}, 1, 0, 1);
    send('{lo, lo, lo, hi, hi, hi, 0, 0, 0}, 0, 0, 1);
    send('{0, 0, lo, 0, 0, hi, 0, 0, 0}, 1, 1, 1);
    send('{lo, lo, lo, hi, hi, hi, 0, 0, 0}, 0, 1, 1);
    // extreme centres
    send('{lo, lo, lo, hi, hi, hi, lo, lo, lo}, 1, 1, 1);
    send('{lo, lo, lo, hi, hi, hi, hi, hi, hi}, 1, 1, 0);
  endtask

  initial begin
    logic [30:0] phase_size[6];
    phase_size = '{31'd1, 31'h7FFF_FFFF, 31'd196609, 31'd0, 31'd32768, 31'd65536};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sizes_used = 1;
    tx_idle = 26;
    rx_idle = 66;
    directed();
    for (int ph = 0; ph < 6; ph++) begin
      write_size(ph == 4 ? 31'($urandom_range(1, 1 << 20)) : phase_size[ph]);
      tx_idle = (ph < 2) ? 26 : (ph < 4) ? 66 : 0;
      rx_idle = (ph < 2) ? 66 : (ph < 4) ? 26 : 0;
      if (ph == 2) hold_req = 4000;
      for (int i = 0; i < 250; i++) random_item(i != 249);
    end
    wait (pending == 0);
    repeat (700) @(posedge clk);
    $display("sent %0d segment requests over %0d voxel sizes, checked %0d results",
             seg_count, sizes_used, res_count);
    if (errors == 0 && pending == 0) begin
      $display("voxel_segment_length_density_core test passed");
    end else begin
      $display("voxel_segment_length_density_core test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("voxel_segment_length_density_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
